>>> rtl/ustk_pkg.sv
// Shared types and constants for the uppercase token scanner.
// No dependencies; every other file of the scanner imports this package.
package ustk_pkg;

   // Fixed field widths.
   localparam int DATA_BITS         = 8;
   localparam int CFG_BITS          = 5;
   localparam int TOKEN_OFFSET_BITS = 32;
   localparam int TOKEN_LENGTH_BITS = 5;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_ADDR_BITS     = 3;

   // Character codes.
   localparam logic [DATA_BITS-1:0] CHAR_A     = 8'h41;
   localparam logic [DATA_BITS-1:0] CHAR_Z     = 8'h5A;
   localparam logic [DATA_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [DATA_BITS-1:0] CHAR_NUL   = 8'h00;

   // Register reset values.
   localparam logic [CFG_BITS-1:0] MIN_BODY_RESET = 5'd2;
   localparam logic [CFG_BITS-1:0] MAX_BODY_RESET = 5'd19;

   // Register indexes, taken from paddr[2].
   localparam logic CSR_MIN_BODY = 1'b0;
   localparam logic CSR_MAX_BODY = 1'b1;

   // Width of one encoder group.
   localparam int GROUP_BITS = 8;

   // Control broadcast to every cell of the window row.
   typedef struct packed {
      logic                shift;
      logic                clear;
      logic [CFG_BITS-1:0] min_body;
      logic [CFG_BITS-1:0] max_body;
   } cell_ctrl_type;

endpackage

>>> rtl/ustk_ifs.sv
// Handshake interfaces for the scanner's byte channel and token channel.
// Depends on ustk_pkg for the field widths.
interface ustk_req_if import ustk_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ustk_rsp_if import ustk_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [TOKEN_OFFSET_BITS-1:0] token_offset;
   logic [TOKEN_LENGTH_BITS-1:0] token_length;

   modport source (output valid, output token_offset, output token_length, input ready);
   modport sink   (input valid, input token_offset, input token_length, output ready);
endinterface

>>> rtl/ustk_cell.sv
// One cell of the letter window row: holds one window bit and flags a hit.
// Depends on ustk_pkg for the cell control struct.
module ustk_cell import ustk_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_BITS   = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          d_in,
   output logic          q_out,
   output logic          hit
);

   localparam int CMP_BITS = (IDX_BITS > CFG_BITS) ? IDX_BITS : CFG_BITS;
   localparam logic [CMP_BITS-1:0] MY_INDEX = CMP_BITS'(CELL_INDEX);

   logic bit_ff;
   logic bit_in;

   // Shift the neighbour's bit in on a body byte; clear on a run break or on a region's last byte.
   always_comb begin
      if (ctrl.clear) begin
         bit_in = 1'b0;
      end else if (ctrl.shift) begin
         bit_in = d_in;
      end else begin
         bit_in = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   // A letter here leads a token whose body length equals this cell's index.
   assign hit = bit_ff && (CELL_INDEX != 0)
                && (MY_INDEX >= CMP_BITS'(ctrl.min_body))
                && (MY_INDEX <= CMP_BITS'(ctrl.max_body));

   assign q_out = bit_ff;

endmodule

>>> rtl/ustk_encoder.sv
// Two-stage priority encoder from the cell hit vector to an offset and length,
// with the result register on the token channel. Depends on ustk_pkg and ustk_ifs.
module ustk_encoder import ustk_pkg::*; #(
   parameter int WIN_BITS    = 20,
   parameter int OFFSET_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [WIN_BITS-1:0]    in_hits,
   input  logic [OFFSET_BITS-1:0] in_pos,
   ustk_rsp_if.source             rsp_bus
);

   localparam int NGRP      = (WIN_BITS + GROUP_BITS - 1) / GROUP_BITS;
   localparam int GSEL_BITS = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int D_BITS    = $clog2(WIN_BITS + 1);
   localparam int PAD_BITS  = NGRP * GROUP_BITS;
   localparam int WIDE_BITS = (OFFSET_BITS > TOKEN_OFFSET_BITS) ? OFFSET_BITS
                                                                : TOKEN_OFFSET_BITS;

   logic [PAD_BITS-1:0]    hits_pad;
   logic [NGRP-1:0]        grp_any;
   logic [2:0]             grp_idx [NGRP];

   logic                   s2_valid_ff;
   logic [NGRP-1:0]        s2_any_ff;
   logic [2:0]             s2_idx_ff [NGRP];
   logic [OFFSET_BITS-1:0] s2_pos_ff;

   logic                   found;
   logic [GSEL_BITS-1:0]   gsel;
   logic [D_BITS-1:0]      body_len;
   logic [D_BITS-1:0]      tok_len;
   logic [OFFSET_BITS-1:0] off_full;
   logic [WIDE_BITS-1:0]   off_wide;

   logic                         rsp_valid_ff;
   logic [TOKEN_OFFSET_BITS-1:0] token_offset_ff;
   logic [TOKEN_LENGTH_BITS-1:0] token_length_ff;
   logic                         out_free;
   logic                         s2_free;

   // Elastic stages: each loads when empty or when its successor moves on.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign in_ready = s2_free;

   assign hits_pad = PAD_BITS'(in_hits);

   // First stage: highest set bit within each group of eight.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any[g] = |hits_pad[g*GROUP_BITS +: GROUP_BITS];
         grp_idx[g] = 3'd0;
         for (int j = 0; j < GROUP_BITS; j++) begin
            if (hits_pad[g*GROUP_BITS + j]) begin
               grp_idx[g] = 3'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_any_ff <= grp_any;
         s2_idx_ff <= grp_idx;
         s2_pos_ff <= in_pos;
      end
   end

   // Second stage: highest group with a hit, then the leading letter's offset.
   always_comb begin
      found = 1'b0;
      gsel  = '0;
      for (int g = 0; g < NGRP; g++) begin
         if (s2_any_ff[g]) begin
            found = 1'b1;
            gsel  = GSEL_BITS'(g);
         end
      end
   end

   assign body_len = D_BITS'({gsel, s2_idx_ff[gsel]});
   assign tok_len  = body_len + D_BITS'(1);
   assign off_full = s2_pos_ff - OFFSET_BITS'(tok_len);
   assign off_wide = WIDE_BITS'(off_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff && found;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         token_offset_ff <= off_wide[TOKEN_OFFSET_BITS-1:0];
         token_length_ff <= TOKEN_LENGTH_BITS'(tok_len);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.token_offset = token_offset_ff;
   assign rsp_bus.token_length = token_length_ff;

endmodule

>>> rtl/uppercase_token_scanner_unit.sv
// Top level of the uppercase token scanner: window cell row, position counter,
// register port and encoder. Depends on ustk_pkg, ustk_ifs, ustk_cell, ustk_encoder.

// The scanner takes one byte beat per clock cycle with no gaps of its own; a
// byte is refused only while the encoder pipeline and the result register are
// all full. A row of MAX_BODY+1 cells shifts the letter marks of the current
// letter-or-space run along by one place per byte. On a zero byte the cells'
// hit flags are captured and go through a two-stage priority encoder and a
// result register before a token beat appears. min_body and max_body sit at
// byte addresses 0 and 4.
module uppercase_token_scanner_unit import ustk_pkg::*; #(
   parameter int MAX_BODY    = 19,
   parameter int OFFSET_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   ustk_req_if.sink                 req_bus,
   ustk_rsp_if.source               rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int WIN_BITS = MAX_BODY + 1;
   localparam int IDX_BITS = $clog2(WIN_BITS);

   logic [CFG_BITS-1:0]    min_body_ff;
   logic [CFG_BITS-1:0]    max_body_ff;
   logic                   csr_write;

   logic                   accept;
   logic                   is_upper;
   logic                   is_body;
   logic                   is_zero;
   cell_ctrl_type          cell_ctrl;
   logic [WIN_BITS-1:0]    win_bits;
   logic [WIN_BITS-1:0]    win_hits;

   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] pos_in;

   logic                   s1_valid_ff;
   logic [WIN_BITS-1:0]    s1_hits_ff;
   logic [OFFSET_BITS-1:0] s1_pos_ff;
   logic                   s1_free;
   logic                   enc_ready;

   // Register port: writes complete in the access phase, never wait.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_body_ff <= MIN_BODY_RESET;
         max_body_ff <= MAX_BODY_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_MIN_BODY: min_body_ff <= pwdata[CFG_BITS-1:0];
            CSR_MAX_BODY: max_body_ff <= pwdata[CFG_BITS-1:0];
            default:      min_body_ff <= min_body_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_MIN_BODY: prdata = CSR_DATA_BITS'(min_body_ff);
         CSR_MAX_BODY: prdata = CSR_DATA_BITS'(max_body_ff);
         default:      prdata = '0;
      endcase
   end

   // Byte classification and the control broadcast to the cell row.
   assign s1_free       = !s1_valid_ff || enc_ready;
   assign req_bus.ready = s1_free;
   assign accept        = req_bus.valid && s1_free;

   assign is_upper = (req_bus.data_byte >= CHAR_A) && (req_bus.data_byte <= CHAR_Z);
   assign is_body  = is_upper || (req_bus.data_byte == CHAR_SPACE);
   assign is_zero  = (req_bus.data_byte == CHAR_NUL);

   assign cell_ctrl.shift    = accept && is_body;
   assign cell_ctrl.clear    = accept && (!is_body || req_bus.last_byte);
   assign cell_ctrl.min_body = min_body_ff;
   assign cell_ctrl.max_body = max_body_ff;

   // Row of window cells; cell 0 takes the new byte's letter mark.
   for (genvar k = 0; k < WIN_BITS; k++) begin : g_cells
      logic shift_src;
      if (k == 0) begin : g_head
         assign shift_src = is_upper;
      end else begin : g_link
         assign shift_src = win_bits[k-1];
      end
      ustk_cell #(
         .CELL_INDEX (k),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (cell_ctrl),
         .d_in  (shift_src),
         .q_out (win_bits[k]),
         .hit   (win_hits[k])
      );
   end

   // Byte position within the region, restarting after the last byte.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = req_bus.last_byte ? '0 : pos_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Capture the hit flags and position of each accepted zero byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept && is_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_hits_ff <= win_hits;
         s1_pos_ff  <= pos_ff;
      end
   end

   ustk_encoder #(
      .WIN_BITS    (WIN_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_encoder (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (enc_ready),
      .in_hits  (s1_hits_ff),
      .in_pos   (s1_pos_ff),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   // A captured zero byte waiting on the encoder keeps its hit flags.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !enc_ready |=> s1_valid_ff && $stable(s1_hits_ff))
      else $error("zero-byte capture changed while stalled");

   // Any accepted byte outside a letter-or-space run empties the window.
   a_run_break: assert property (@(posedge clock) disable iff (reset)
      accept && !is_body |=> win_bits == '0)
      else $error("window not cleared after run break");

   // The last byte of a region restarts the position count and empties the window.
   a_region_end: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_byte |=> pos_ff == '0 && win_bits == '0)
      else $error("state not cleared after last byte");
`endif

endmodule
